### design/dlms_pkg.sv
// ----------------------------------------------------------------------------
// dlms_pkg: shared types and constants for the DFA longest-match scanner
// Widths, input kind codes, queue item format and table geometry.
// ----------------------------------------------------------------------------
package dlms_pkg;

  // field widths
  localparam int KIND_W  = 2;
  localparam int STATE_W = 8;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;

  // table geometry: one entry per (state, byte)
  localparam int NUM_STATES = 256;
  localparam int ALPHABET   = 256;
  localparam int TBL_DEPTH  = NUM_STATES * ALPHABET;
  localparam int TBL_AW     = STATE_W + BYTE_W;

  // front/back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD_TRANS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_ACCEPT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN        = 2'd2;

  // special states
  localparam logic [STATE_W-1:0] START_STATE = 8'd1;
  localparam logic [STATE_W-1:0] ERROR_STATE = 8'd0;

  // operation carried through the queue
  typedef enum logic [1:0] {
    OP_LOAD_TRANS  = 2'd0,
    OP_LOAD_ACCEPT = 2'd1,
    OP_SCAN        = 2'd2
  } op_e;

  // one queued beat
  typedef struct packed {
    op_e                op;
    logic [STATE_W-1:0] st;    // from_state of a load
    logic [BYTE_W-1:0]  byt;   // on_byte of a load or data_byte of a scan
    logic [STATE_W-1:0] nxt;   // to_state of a transition load
    logic               abit;  // accept flag of a flag load
    logic               last;  // last byte of the string
  } item_t;

endpackage

### design/dlms_front.sv
// ----------------------------------------------------------------------------
// dlms_front: input intake and classification
// Takes input beats, decodes the kind, drops unknown kinds and queues the
// rest for the back end in a small FIFO.
// ----------------------------------------------------------------------------
module dlms_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dlms_pkg::KIND_W-1:0]   kind_i,
  input  logic [dlms_pkg::STATE_W-1:0]  from_state_i,
  input  logic [dlms_pkg::BYTE_W-1:0]   on_byte_i,
  input  logic [dlms_pkg::STATE_W-1:0]  to_state_i,
  input  logic                          accept_bit_i,
  input  logic [dlms_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                          last_byte_i,
  output logic                          q_valid_o,
  output dlms_pkg::item_t               q_item_o,
  input  logic                          q_pop_i
);
  import dlms_pkg::*;

  item_t               q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     cnt_q;
  item_t               item_d;
  logic                keep;
  logic                push;

  // classify the incoming beat
  always_comb begin
    keep        = 1'b1;
    item_d.op   = OP_SCAN;
    item_d.st   = from_state_i;
    item_d.byt  = on_byte_i;
    item_d.nxt  = to_state_i;
    item_d.abit = accept_bit_i;
    item_d.last = last_byte_i;
    unique case (kind_i)
      KIND_LOAD_TRANS:  item_d.op = OP_LOAD_TRANS;
      KIND_LOAD_ACCEPT: item_d.op = OP_LOAD_ACCEPT;
      KIND_SCAN: begin
        item_d.op  = OP_SCAN;
        item_d.byt = data_byte_i;
      end
      default:          keep = 1'b0;  // unknown kind: taken and dropped
    endcase
  end

  assign in_stall_o = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o && keep;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = q_mem[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item_d;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      unique case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### design/dlms_back.sv
// ----------------------------------------------------------------------------
// dlms_back: table memories and scan pipeline
// Issue stage writes loads and reads the next-state table, B stage steps the
// DFA state and reads the accept flag, C stage tracks the longest match, and
// an output register holds the result of each last byte.
// ----------------------------------------------------------------------------
module dlms_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  dlms_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [dlms_pkg::LEN_W-1:0]    match_length_o,
  output logic                          hit_error_o
);
  import dlms_pkg::*;

  // memories
  logic [STATE_W-1:0] tbl_mem  [TBL_DEPTH];
  logic               flag_mem [NUM_STATES];
  logic [STATE_W-1:0] tbl_rd_q;
  logic               flag_rd_q;

  // per-string state
  logic [STATE_W-1:0] st_q;
  logic [LEN_W-1:0]   pos_q;
  logic               dead_q;
  logic [LEN_W-1:0]   lm_q;

  // pipeline stages
  logic               b_v_q, b_last_q;
  logic               c_v_q, c_last_q, c_upd_q, c_dead_q;
  logic [LEN_W-1:0]   c_pos_q;
  logic               out_v_q, acc_q, hit_q;
  logic [LEN_W-1:0]   mlen_q;

  logic               adv;
  logic               issue_scan, wr_trans, wr_acc;
  logic               live;
  logic [LEN_W-1:0]   pos_n;
  logic [STATE_W-1:0] st_n, cur_eff;
  logic               dead_n, upd_n;
  logic [LEN_W-1:0]   lm_n;

  // whole pipeline moves unless a held result is stalled
  assign adv        = !(out_v_q && out_stall_i);
  assign q_pop_o    = adv && q_valid_i;
  assign issue_scan = q_pop_o && (q_item_i.op == OP_SCAN);
  assign wr_trans   = q_pop_o && (q_item_i.op == OP_LOAD_TRANS);
  assign wr_acc     = q_pop_o && (q_item_i.op == OP_LOAD_ACCEPT);

  // B stage: step the DFA with the table word registered at issue
  always_comb begin
    live   = !dead_q;
    pos_n  = pos_q;
    st_n   = st_q;
    dead_n = dead_q;
    upd_n  = 1'b0;
    if (live) begin
      pos_n  = (pos_q == '1) ? pos_q : pos_q + LEN_W'(1);
      st_n   = tbl_rd_q;
      dead_n = (tbl_rd_q == ERROR_STATE);
      upd_n  = (tbl_rd_q != ERROR_STATE);
    end
  end

  // state seen by the scan being issued: bypass from B
  always_comb begin
    cur_eff = st_q;
    if (b_v_q) begin
      cur_eff = b_last_q ? START_STATE : st_n;
    end
  end

  // next-state table: one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_trans) begin
      tbl_mem[{q_item_i.st, q_item_i.byt}] <= q_item_i.nxt;
    end
    if (issue_scan) begin
      tbl_rd_q <= tbl_mem[{cur_eff, q_item_i.byt}];
    end
  end

  // accept flags: written at issue, read for the state reached in B
  always_ff @(posedge clk_i) begin
    if (wr_acc) begin
      flag_mem[q_item_i.st] <= q_item_i.abit;
    end
    if (adv && b_v_q) begin
      flag_rd_q <= flag_mem[st_n];
    end
  end

  // C stage: longest accepting prefix
  assign lm_n = (c_upd_q && flag_rd_q) ? c_pos_q : lm_q;

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_last_q <= q_item_i.last;
      c_last_q <= b_last_q;
      c_upd_q  <= upd_n;
      c_dead_q <= dead_n;
      c_pos_q  <= pos_n;
      if (c_v_q && c_last_q) begin
        acc_q  <= !c_dead_q && flag_rd_q;
        mlen_q <= lm_n;
        hit_q  <= c_dead_q;
      end
    end
  end

  // control and string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      st_q    <= START_STATE;
      pos_q   <= '0;
      dead_q  <= 1'b0;
      lm_q    <= '0;
    end else if (adv) begin
      b_v_q   <= issue_scan;
      c_v_q   <= b_v_q;
      out_v_q <= c_v_q && c_last_q;
      if (b_v_q) begin
        if (b_last_q) begin
          st_q   <= START_STATE;
          pos_q  <= '0;
          dead_q <= 1'b0;
        end else begin
          st_q   <= st_n;
          pos_q  <= pos_n;
          dead_q <= dead_n;
        end
      end
      if (c_v_q) begin
        lm_q <= c_last_q ? '0 : lm_n;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign accepted_o     = acc_q;
  assign match_length_o = mlen_q;
  assign hit_error_o    = hit_q;

endmodule

### design/dfa_longest_match_scanner.sv
// ----------------------------------------------------------------------------
// dfa_longest_match_scanner: table-driven DFA longest-match scanner
// Loads a next-state table and accept flags, scans strings a byte at a time
// and reports accept, longest match length and error on each last byte.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i/in_stall_o  | kind, from_state, on_byte,
//           |           |                        | to_state, accept_bit,
//           |           |                        | data_byte, last_byte
//   out     | output    | out_valid_o/out_stall_i| accepted, match_length,
//           |           |                        | hit_error
//
// One beat per cycle sustained while no output stall holds the pipeline; the
// table read feeds the next table address through the B-stage state bypass.
// A result reaches the output register via the queue and issue, B and C stages.
// Reset clears the queue, pipeline and string state; table and flag memories
// hold no reset value and must be loaded before use.
// An output stall freezes the back pipeline; the 4-entry queue keeps taking
// beats until it fills.
// ----------------------------------------------------------------------------
module dfa_longest_match_scanner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dlms_pkg::KIND_W-1:0]   kind_i,
  input  logic [dlms_pkg::STATE_W-1:0]  from_state_i,
  input  logic [dlms_pkg::BYTE_W-1:0]   on_byte_i,
  input  logic [dlms_pkg::STATE_W-1:0]  to_state_i,
  input  logic                          accept_bit_i,
  input  logic [dlms_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [dlms_pkg::LEN_W-1:0]    match_length_o,
  output logic                          hit_error_o
);
  import dlms_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // intake and queue
  dlms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .from_state_i (from_state_i),
    .on_byte_i    (on_byte_i),
    .to_state_i   (to_state_i),
    .accept_bit_i (accept_bit_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  // tables and scan pipeline
  dlms_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .match_length_o (match_length_o),
    .hit_error_o    (hit_error_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the DFA longest-match scanner
// Loads transitions and accept flags, scans strings over the table walked so
// far, and checks every verdict against an in-bench DFA predictor or a pinned
// hand-typed verdict. A short table of hand-written beats comes first, then
// random strings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import dlms_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 340;
  localparam int PRESSURE_AT = 120;
  localparam int PAUSE_AT    = 250;
  localparam int CALM_AT     = RAND_ITEMS - 60;
  localparam int HOLD_CYCLES = 60;
  localparam int LIMIT       = 2000;
  localparam int LONG_REPS   = 20;

  typedef logic [STATE_W-1:0] state_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  // one input beat, in port order
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    state_t            from_st;
    byte_t             on_byte;
    state_t            to_st;
    logic              abit;
    byte_t             data;
    logic              last;
  } beat_t;

  // one string verdict
  typedef struct packed {
    logic             acc;
    logic [LEN_W-1:0] len;
    logic             err;
  } verdict_t;

  // directed stimulus row; reps repeats the beat, last applies to the final one
  typedef struct {
    beat_t    b;
    int       reps;
    bit       typed;
    verdict_t v;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [KIND_W-1:0] kind_i;
  state_t           from_state_i;
  byte_t            on_byte_i;
  state_t           to_state_i;
  logic             accept_bit_i;
  byte_t            data_byte_i;
  logic             last_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             accepted_o;
  logic [LEN_W-1:0] match_length_o;
  logic             hit_error_o;

  dfa_longest_match_scanner u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .from_state_i   (from_state_i),
    .on_byte_i      (on_byte_i),
    .to_state_i     (to_state_i),
    .accept_bit_i   (accept_bit_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .match_length_o (match_length_o),
    .hit_error_o    (hit_error_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor copy of the tables and the string walk
  state_t     dfa_next       [TBL_DEPTH];
  bit         dfa_next_set   [TBL_DEPTH];
  bit         dfa_accept     [NUM_STATES];
  bit         dfa_accept_set [NUM_STATES];
  state_t     scan_state = START_STATE;
  logic [LEN_W-1:0] scan_pos  = '0;
  logic [LEN_W-1:0] scan_best = '0;
  bit         scan_dead = 1'b0;
  verdict_t   verdict_q [$];

  // hand-typed verdict that replaces the prediction for the current beat
  bit         pinned_valid = 1'b0;
  verdict_t   pinned_verdict;

  bit         in_take  = 1'b0;
  bit         out_take = 1'b0;
  bit         calm     = 1'b0;
  bit         hold_req = 1'b0;
  int         str_left = 0;
  int         mismatches = 0;
  int         beats_sent = 0;
  int         verdicts_seen = 0;
  int         best_seen = 0;
  int         fill_stalls = 0;
  int         idle_cycles = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH verdict %0d %s: got %0d, expected %0d", verdicts_seen, what, got, want);
    mismatches++;
  endtask

  // walk one accepted beat through the predictor
  function automatic void dfa_advance(input beat_t b);
    verdict_t v;
    state_t   nxt;
    case (b.kind)
      KIND_LOAD_TRANS: begin
        dfa_next[{b.from_st, b.on_byte}]     = b.to_st;
        dfa_next_set[{b.from_st, b.on_byte}] = 1'b1;
      end
      KIND_LOAD_ACCEPT: begin
        dfa_accept[b.from_st]     = b.abit;
        dfa_accept_set[b.from_st] = 1'b1;
      end
      KIND_SCAN: begin
        if (!scan_dead) begin
          if (scan_pos != '1) scan_pos++;
          nxt = dfa_next[{scan_state, b.data}];
          scan_state = nxt;
          if (nxt == ERROR_STATE) scan_dead = 1'b1;
          else if (dfa_accept[nxt]) scan_best = scan_pos;
        end
        if (b.last) begin
          v.acc = !scan_dead && dfa_accept[scan_state];
          v.len = scan_best;
          v.err = scan_dead;
          verdict_q.push_back(pinned_valid ? pinned_verdict : v);
          scan_state = START_STATE;
          scan_pos   = '0;
          scan_best  = '0;
          scan_dead  = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // a byte may be scanned only if its entry and the target's flag are loaded
  function automatic bit walkable(input state_t s, input byte_t c);
    state_t tgt;
    tgt = dfa_next[{s, c}];
    return dfa_next_set[{s, c}] && (tgt == ERROR_STATE || dfa_accept_set[tgt]);
  endfunction

  function automatic state_t pick_target();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return ERROR_STATE;
    if (roll < 70) return state_t'($urandom_range(1, 6));
    return state_t'($urandom_range(0, 255));
  endfunction

  // next random beat; mostly scans along known paths, growing the table as needed
  function automatic void make_beat(output beat_t b, input bit force_last);
    int     roll;
    int     cands [$];
    state_t tgt;
    b.kind    = KIND_SCAN;
    b.from_st = state_t'($urandom);
    b.on_byte = byte_t'($urandom);
    b.to_st   = state_t'($urandom);
    b.abit    = 1'($urandom);
    b.data    = byte_t'($urandom);
    b.last    = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      b.kind = KIND_UNUSED;
      return;
    end
    if (roll < 11) begin
      b.kind = KIND_LOAD_ACCEPT;
      return;
    end
    if (roll < 16) begin
      b.kind = KIND_LOAD_TRANS;
      return;
    end
    for (int i = 0; i < ALPHABET; i++)
      if (walkable(scan_state, byte_t'(i))) cands.push_back(i);
    if (cands.size() == 0 || (roll < 24 && !scan_dead)) begin
      tgt = pick_target();
      // a target needs its flag loaded before any transition may lead to it
      if (tgt != ERROR_STATE && !dfa_accept_set[tgt]) begin
        b.kind    = KIND_LOAD_ACCEPT;
        b.from_st = tgt;
        return;
      end
      b.kind    = KIND_LOAD_TRANS;
      b.from_st = scan_state;
      b.to_st   = tgt;
      return;
    end
    b.data = byte_t'(cands[$urandom_range(0, cands.size() - 1)]);
    if (str_left == 0)
      str_left = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 120) : $urandom_range(1, 6);
    b.last   = force_last || str_left == 1;
    str_left = b.last ? 0 : str_left - 1;
  endfunction

  function automatic row_t mk_row(input logic [KIND_W-1:0] kind, input state_t st,
                                  input byte_t byt, input state_t nxt, input logic abit,
                                  input logic last, input int reps = 1, input bit typed = 0,
                                  input logic acc = 0, input int len = 0, input logic err = 0);
    row_t r;
    r.b     = '{kind: kind, from_st: st, on_byte: byt, to_st: nxt, abit: abit,
                data: byt, last: last};
    r.reps  = reps;
    r.typed = typed;
    r.v     = '{acc: acc, len: len[LEN_W-1:0], err: err};
    return r;
  endfunction

  task automatic send_beat(input beat_t b);
    in_valid_i   <= 1'b1;
    kind_i       <= b.kind;
    from_state_i <= b.from_st;
    on_byte_i    <= b.on_byte;
    to_state_i   <= b.to_st;
    accept_bit_i <= b.abit;
    data_byte_i  <= b.data;
    last_byte_i  <= b.last;
    @(posedge clk_i);
    while (!in_take) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // sample both channels mid-cycle, predict, check and watch for hangs
  always @(negedge clk_i) begin
    verdict_t want;
    in_take  = rst_ni && in_valid_i === 1'b1 && in_stall_o === 1'b0;
    out_take = rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0;
    if (in_valid_i === 1'b1 && in_stall_o === 1'b1) fill_stalls++;
    if (in_take)
      dfa_advance({kind_i, from_state_i, on_byte_i, to_state_i, accept_bit_i,
                   data_byte_i, last_byte_i});
    if (out_take) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch("arrived with none pending", 1, 0);
      end else begin
        want = verdict_q.pop_front();
        if (accepted_o !== want.acc) flag_mismatch("accepted", accepted_o, want.acc);
        if (match_length_o !== want.len)
          flag_mismatch("match_length", match_length_o, want.len);
        if (hit_error_o !== want.err) flag_mismatch("hit_error", hit_error_o, want.err);
        if (match_length_o > best_seen) best_seen = match_length_o;
      end
      verdicts_seen++;
    end
    idle_cycles = (in_take || out_take) ? 0 : idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("Watchdog: %0d cycles without an accepted beat", LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request, none once calm
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rst_ni && !calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // sender: directed table, then random strings
  initial begin
    row_t  script [$];
    beat_t b;
    int    n;
    int    burst;
    int    directed_beats;

    in_valid_i   = 1'b0;
    kind_i       = KIND_SCAN;
    from_state_i = '0;
    on_byte_i    = '0;
    to_state_i   = '0;
    accept_bit_i = 1'b0;
    data_byte_i  = '0;
    last_byte_i  = 1'b0;
    rst_ni       = 1'b0;

    // small DFA: 1 -00-> 2 (accepting) -FF-> 255 (accepting, FF self loop),
    // 2 -00-> error; error-state entries loaded so dead bytes read known data
    script.push_back(mk_row(KIND_LOAD_ACCEPT, ERROR_STATE, 8'h00, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_LOAD_ACCEPT, START_STATE, 8'h00, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_LOAD_ACCEPT, 8'd2, 8'h00, 8'h00, 1'b1, 1'b0));
    script.push_back(mk_row(KIND_LOAD_ACCEPT, 8'd255, 8'h00, 8'h00, 1'b1, 1'b0));
    script.push_back(mk_row(KIND_LOAD_TRANS, START_STATE, 8'h00, 8'd2, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_LOAD_TRANS, 8'd2, 8'hFF, 8'd255, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_LOAD_TRANS, 8'd255, 8'hFF, 8'd255, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_LOAD_TRANS, 8'd2, 8'h00, ERROR_STATE, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_LOAD_TRANS, ERROR_STATE, 8'h00, ERROR_STATE, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_LOAD_TRANS, ERROR_STATE, 8'hFF, ERROR_STATE, 1'b0, 1'b0));
    // unknown kind carrying a last flag: no verdict
    script.push_back(mk_row(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    // one-byte accepting string
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1, 1, 1'b1, 1, 1'b0));
    // three bytes ending in the accepting self loop
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1, 1, 1'b1, 3, 1'b0));
    // error mid-string, trailing byte after the error still ends the string
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1, 1, 1'b0, 1, 1'b1));
    // 255 turned non-accepting: ends unaccepted but keeps the earlier match
    script.push_back(mk_row(KIND_LOAD_ACCEPT, 8'd255, 8'h00, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1, 1, 1'b0, 1, 1'b0));
    // longer string through the self loop
    script.push_back(mk_row(KIND_LOAD_ACCEPT, 8'd255, 8'h00, 8'h00, 1'b1, 1'b0));
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, LONG_REPS, 1,
                            1'b1, LONG_REPS + 1, 1'b0));
    // next string starts clean
    script.push_back(mk_row(KIND_SCAN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1, 1, 1'b1, 1, 1'b0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      for (int r = 0; r < script[i].reps; r++) begin
        b = script[i].b;
        b.last = b.last && (r == script[i].reps - 1);
        pinned_valid   = script[i].typed && b.last;
        pinned_verdict = script[i].v;
        send_beat(b);
        pinned_valid = 1'b0;
      end
      sender_gap();
    end
    directed_beats = beats_sent;

    // sender waits for every pending verdict before the random part
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);

    n = 0;
    burst = 0;
    while (n < RAND_ITEMS) begin
      if (n == PRESSURE_AT && burst == 0) begin
        // receiver holds off while one-byte strings stream in back to back
        hold_req = 1'b1;
        burst = 24;
      end
      if (n == PAUSE_AT && burst == 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (verdict_q.size() != 0) @(posedge clk_i);
      end
      if (n >= CALM_AT) calm = 1'b1;
      make_beat(b, burst > 0);
      send_beat(b);
      if (b.kind != KIND_UNUSED) n++;
      if (burst > 0) burst--;
      else sender_gap();
    end

    // drain
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d input beats (%0d directed, incl. a long self loop) and %0d verdicts.",
             beats_sent, directed_beats, verdicts_seen);
    $display("Longest match reported %0d; input held off on %0d cycles; %0d mismatches.",
             best_seen, fill_stalls, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
